FILE: rtl/div128_pkg.sv
// ----------------------------------------------------------------------------
// div128_pkg
// Shared types for the 128-by-64 unsigned divider: item structs, controller
// states, and the command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
package div128_pkg;

  localparam int unsigned NumWidth   = 128;
  localparam int unsigned DenWidth   = 64;
  localparam int unsigned CountWidth = $clog2(NumWidth);

  typedef struct packed {
    logic [63:0] numerator_high;
    logic [63:0] numerator_low;
    logic [63:0] divisor;
  } req_item_t;

  typedef struct packed {
    logic [63:0] quotient_high;
    logic [63:0] quotient_low;
    logic [63:0] remainder;
    logic        divide_by_zero;
  } rsp_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic zero_divisor;
  } status_t;

endpackage

FILE: rtl/divide_128_by_64.sv
// ----------------------------------------------------------------------------
// divide_128_by_64
// Unsigned 128-bit by 64-bit shift-subtract divider with divide-by-zero flag.
// Each accepted item takes 128 steps of one quotient bit per cycle, then its
// result is loaded into the output register; a zero divisor skips the steps.
// A new item is accepted only once the previous result has been loaded into
// the output register, which waits while a held result is stalled.
// Reset clears the sequencer and output valid; data registers are not reset.
// ----------------------------------------------------------------------------
module divide_128_by_64 (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  div128_pkg::req_item_t req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output div128_pkg::rsp_item_t rsp
);
  import div128_pkg::*;

  cmd_t    cmd;
  status_t status;

  div128_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  div128_dp u_dp (
    .clk    (clk),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

endmodule

FILE: rtl/div128_dp.sv
// ----------------------------------------------------------------------------
// div128_dp
// Restoring divider datapath: shift register that trades dividend bits for
// quotient bits, a 64-bit partial remainder, one 65-bit trial subtract per step.
// ----------------------------------------------------------------------------
module div128_dp (
  input  logic                  clk,
  input  div128_pkg::req_item_t req,
  input  div128_pkg::cmd_t      cmd,
  output div128_pkg::status_t   status,
  output div128_pkg::rsp_item_t rsp
);
  import div128_pkg::*;

  logic [NumWidth-1:0] work;
  logic [DenWidth-1:0] rem;
  logic [DenWidth-1:0] den;
  logic                dz;

  logic [DenWidth:0]   trial;
  logic [DenWidth:0]   diff;
  logic                ge;

  assign status.zero_divisor = (req.divisor == '0);

  assign trial = {rem, work[NumWidth-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = ~diff[DenWidth];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= {req.numerator_high, req.numerator_low};
      rem  <= '0;
      den  <= req.divisor;
      dz   <= status.zero_divisor;
    end else if (cmd.step) begin
      work <= {work[NumWidth-2:0], ge};
      rem  <= ge ? diff[DenWidth-1:0] : trial[DenWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (dz) begin
        rsp <= '{quotient_high: '0, quotient_low: '0, remainder: '0,
                 divide_by_zero: 1'b1};
      end else begin
        rsp <= '{quotient_high: work[NumWidth-1:DenWidth],
                 quotient_low: work[DenWidth-1:0], remainder: rem,
                 divide_by_zero: 1'b0};
      end
    end
  end

endmodule

FILE: rtl/div128_ctrl.sv
// ----------------------------------------------------------------------------
// div128_ctrl
// Divider sequencer: takes an item, runs 128 shift-subtract steps (none for
// a zero divisor), then hands the result to the output register when free.
// ----------------------------------------------------------------------------
module div128_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  div128_pkg::status_t status,
  output div128_pkg::cmd_t    cmd
);
  import div128_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [CountWidth-1:0] count;
  logic                  last_step;
  logic                  slot_free;

  assign last_step = (count == CountWidth'(NumWidth - 1));
  assign slot_free = ~rsp_valid | ~rsp_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = status.zero_divisor ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_stall  = 1'b1;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = slot_free;
      end
      default: req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        count <= '0;
      end else if (cmd.step) begin
        count <= count + 1'b1;
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
